// ===== hdl/tlsq_pkg.sv =====
package tlsq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int NUM_LEVELS  = 3;
    localparam int LVL_W       = 2;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 8;
    localparam int STATUS_W    = 2;

    // position counters hold 0..QUEUE_DEPTH inclusive
    localparam int PTR_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CMP_W  = (PTR_W > CFG_W) ? PTR_W : CFG_W;

    localparam logic [CFG_W-1:0] QSIZE_RST = 8'd128;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/tlsq_ram.sv =====
module tlsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tlsq_ctrl.sv =====
module tlsq_ctrl
    import tlsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_tready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.exec = i_s_tvalid;
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/tlsq_dp.sv =====
module tlsq_dp
    import tlsq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_op,
    input  logic [VAL_W-1:0]    i_value,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output t_status             o_status,
    output logic [LVL_W-1:0]    o_level,
    output logic [VAL_W-1:0]    o_value
);

    logic [PTR_W-1:0] r_wp [NUM_LEVELS];
    logic [PTR_W-1:0] r_rp [NUM_LEVELS];
    logic [PTR_W-1:0] rp_inc [NUM_LEVELS];
    logic [CFG_W-1:0] r_qsize;

    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] eff_size;

    logic [NUM_LEVELS-1:0] ins_oh;
    logic [NUM_LEVELS-1:0] del_oh;
    logic [NUM_LEVELS-1:0] ram_we;
    logic [NUM_LEVELS-1:0] ram_re;
    logic [VAL_W-1:0]      ram_rdata [NUM_LEVELS];

    t_status          n_status;
    logic [LVL_W-1:0] n_level;
    t_status          r_status;
    logic [LVL_W-1:0] r_level;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [LVL_W-1:0] r_out_level;
    logic [VAL_W-1:0] r_out_value;
    logic [VAL_W-1:0] rdata_sel;

    // a size of zero acts as one, anything above the depth saturates
    always_comb begin
        size_ext = CMP_W'(r_qsize);
        if (size_ext == '0) begin
            eff_size = CMP_W'(1);
        end else if (size_ext > CMP_W'(QUEUE_DEPTH)) begin
            eff_size = CMP_W'(QUEUE_DEPTH);
        end else begin
            eff_size = size_ext;
        end
    end

    // lowest-numbered level wins on both insert and delete
    always_comb begin
        logic ins_found;
        logic del_found;
        logic [LVL_W-1:0] ins_lvl;
        logic [LVL_W-1:0] del_lvl;
        ins_found = 1'b0;
        del_found = 1'b0;
        ins_lvl   = '0;
        del_lvl   = '0;
        ins_oh    = '0;
        del_oh    = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            rp_inc[k] = r_rp[k] + PTR_W'(1);
            if (!ins_found && (CMP_W'(r_wp[k]) < eff_size)) begin
                ins_found = 1'b1;
                ins_oh[k] = 1'b1;
                ins_lvl   = LVL_W'(k);
            end
            if (!del_found && (r_rp[k] < r_wp[k])) begin
                del_found = 1'b1;
                del_oh[k] = 1'b1;
                del_lvl   = LVL_W'(k);
            end
        end
        if (i_op == OP_INSERT) begin
            n_status = ins_found ? ST_INSERTED : ST_FULL;
            n_level  = ins_lvl;
        end else begin
            n_status = del_found ? ST_REMOVED : ST_EMPTY;
            n_level  = del_lvl;
        end
        ram_we = (i_cmd.exec && (i_op == OP_INSERT)) ? ins_oh : '0;
        ram_re = (i_cmd.exec && (i_op == OP_DELETE)) ? del_oh : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsize <= QSIZE_RST;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_wp[k] <= '0;
                r_rp[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_qsize <= i_cfg_wdata;
            end
            for (int k = 0; k < NUM_LEVELS; k++) begin
                if (ram_we[k]) begin
                    r_wp[k] <= r_wp[k] + PTR_W'(1);
                end else if (ram_re[k]) begin
                    // drained: both positions return to zero
                    if (rp_inc[k] >= r_wp[k]) begin
                        r_rp[k] <= '0;
                        r_wp[k] <= '0;
                    end else begin
                        r_rp[k] <= rp_inc[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_level  <= n_level;
        end
    end

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl
        tlsq_ram #(
            .WIDTH (VAL_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (r_wp[g][ADDR_W-1:0]),
            .i_wdata (i_value),
            .i_re    (ram_re[g]),
            .i_raddr (r_rp[g][ADDR_W-1:0]),
            .o_rdata (ram_rdata[g])
        );
    end

    assign rdata_sel = ram_rdata[r_level];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_level  <= r_level;
            r_out_value  <= (r_status == ST_REMOVED) ? rdata_sel : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_status        = r_out_status;
    assign o_level         = r_out_level;
    assign o_value         = r_out_value;

endmodule

// ===== hdl/three_level_spill_queue.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: value
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: queue_index, removed_value
// cfg       in   i_cfg_we                      i_cfg_wdata: queue_size
//
// Per item: the accept edge picks the level, updates its positions and writes
// or reads the level's RAM; once the output register is free, the registered read
// data moves into it. No new item is accepted until then, so a stalled output stalls input.
// Reset is synchronous; it clears positions and sets size to 128; RAM contents are not cleared.
module three_level_spill_queue
    import tlsq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic                   s_axis_tuser,  // [0] op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [1:0] queue_index, [33:2] removed_value
    output logic [STATUS_W-1:0]    m_axis_tuser,  // [1:0] status
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_cmd             cmd;
    t_stat            stat;
    t_status          out_status;
    logic [LVL_W-1:0] out_level;
    logic [VAL_W-1:0] out_value;

    tlsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_s_tready (s_axis_tready)
    );

    tlsq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata[VAL_W-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_status    (out_status),
        .o_level     (out_level),
        .o_value     (out_value)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {{(OUT_TDATA_W - VAL_W - LVL_W){1'b0}}, out_value, out_level};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous item still in flight");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("result load did not raise output valid");

    a_exec_load_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !cmd.load_out)
        else $error("execute and result load in the same cycle");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_REMOVED) |-> (m_axis_tdata[33:2] == '0))
        else $error("non-zero value on a result that removed nothing");

endmodule
